>>> rtl/obg_pkg.sv
// obg_pkg: shared types, constants and the control store for the opaque box grower.
// Used by obg_seq, obg_dp and opaque_bbox_grow; depends on nothing else.
package obg_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam int DIM_W   = 9;
	localparam int PASS_W  = 10;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int STEP_W  = 4;

	localparam logic [DIM_W-1:0]  DIM_RESET  = 9'd256;
	localparam logic [PASS_W-1:0] PASS_LIMIT = 10'd1023;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BOTTOM_UP    = 2'd2;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_PASS,
		OP_START,
		OP_CHECK,
		OP_TEST,
		OP_DONE
	} op_t;

	typedef enum logic [1:0] {
		DIR_LEFT,
		DIR_RIGHT,
		DIR_TOP,
		DIR_BOTTOM
	} dir_t;

	typedef struct packed {
		op_t   op;
		dir_t  dir;
		step_t tgt_a;
		step_t tgt_b;
	} ctl_word_t;

	typedef struct packed {
		logic start;
		logic at_limit;
		logic span_empty;
		logic hit;
		logic at_end;
		logic changed;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic               action;
		logic [7:0]         pixel_col;
		logic [7:0]         pixel_row;
		logic [7:0]         alpha;
		logic signed [15:0] seed_left;
		logic signed [15:0] seed_right;
		logic signed [15:0] seed_top;
		logic signed [15:0] seed_bottom;
	} in_word_t;

	typedef struct packed {
		logic [7:0]        box_left;
		logic [7:0]        box_right;
		logic [7:0]        box_top;
		logic [7:0]        box_bottom;
		logic [PASS_W-1:0] pass_count;
	} out_word_t;

	// program steps
	localparam step_t STEP_IDLE     = 4'd0;
	localparam step_t STEP_PASS     = 4'd1;
	localparam step_t STEP_L_START  = 4'd2;
	localparam step_t STEP_L_CHECK  = 4'd3;
	localparam step_t STEP_R_START  = 4'd4;
	localparam step_t STEP_R_CHECK  = 4'd5;
	localparam step_t STEP_T_START  = 4'd6;
	localparam step_t STEP_T_CHECK  = 4'd7;
	localparam step_t STEP_B_START  = 4'd8;
	localparam step_t STEP_B_CHECK  = 4'd9;
	localparam step_t STEP_TEST     = 4'd10;
	localparam step_t STEP_DONE     = 4'd11;

	// Control store. START: tgt_a scans, tgt_b skips the walk.
	// CHECK: tgt_a after a hit, tgt_b when the span is exhausted.
	function automatic ctl_word_t ctl_rom(input step_t pc);
		ctl_word_t w;
		w = '{op: OP_IDLE, dir: DIR_LEFT, tgt_a: STEP_IDLE, tgt_b: STEP_IDLE};
		unique case (pc)
			STEP_IDLE:    w = '{OP_IDLE,  DIR_LEFT,   STEP_PASS,    STEP_IDLE};
			STEP_PASS:    w = '{OP_PASS,  DIR_LEFT,   STEP_L_START, STEP_L_START};
			STEP_L_START: w = '{OP_START, DIR_LEFT,   STEP_L_CHECK, STEP_R_START};
			STEP_L_CHECK: w = '{OP_CHECK, DIR_LEFT,   STEP_L_START, STEP_R_START};
			STEP_R_START: w = '{OP_START, DIR_RIGHT,  STEP_R_CHECK, STEP_T_START};
			STEP_R_CHECK: w = '{OP_CHECK, DIR_RIGHT,  STEP_R_START, STEP_T_START};
			STEP_T_START: w = '{OP_START, DIR_TOP,    STEP_T_CHECK, STEP_B_START};
			STEP_T_CHECK: w = '{OP_CHECK, DIR_TOP,    STEP_T_START, STEP_B_START};
			STEP_B_START: w = '{OP_START, DIR_BOTTOM, STEP_B_CHECK, STEP_TEST};
			STEP_B_CHECK: w = '{OP_CHECK, DIR_BOTTOM, STEP_B_START, STEP_TEST};
			STEP_TEST:    w = '{OP_TEST,  DIR_LEFT,   STEP_PASS,    STEP_DONE};
			STEP_DONE:    w = '{OP_DONE,  DIR_LEFT,   STEP_IDLE,    STEP_IDLE};
			default:      w = '{OP_IDLE,  DIR_LEFT,   STEP_IDLE,    STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

>>> rtl/opaque_bbox_grow.sv
// opaque_bbox_grow: top level with the APB register file, sequencer and datapath.
// Depends on obg_pkg, obg_seq and obg_dp.
//
// Usage:
//   Input words carry either a pixel load (action 0) or a box grow (action 1).
//   A load writes one bit of the opaque mask in the idle step; loads
//   may follow each other on every clock. A grow word is held in the
//   sequencer until its result word has been placed in the output register.
//   A grow passes through the IDLE step that takes it and the DONE step;
//   per pass, a PASS and a TEST step of bookkeeping; per walk, a START step
//   per edge step tried and a CHECK step per mask bit scanned along the
//   neighbouring column or row (one read per cycle, single-port mask memory).
//   The output word sits in a register: while the receiver stalls, it holds,
//   and the next input word is still taken; only a second finished grow
//   waits in the DONE step until the register is free.
//   Reset clears the step counter, the output valid and the registers
//   (width 256, height 256, bottom_up 0). The mask is not cleared: load every
//   pixel that a grow can reach before issuing it.
//   Write registers over APB only while the block is idle; the block does not enforce it.
module opaque_bbox_grow #(
	parameter int MAX_WIDTH  = obg_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = obg_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [obg_pkg::PADDR_W-1:0]   paddr,
	input  logic [obg_pkg::PDATA_W-1:0]   pwdata,
	output logic [obg_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  obg_pkg::in_word_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output obg_pkg::out_word_t            out_data
);
	import obg_pkg::*;

	logic [DIM_W-1:0] image_width_q;
	logic [DIM_W-1:0] image_height_q;
	logic             bottom_up_q;
	logic             wr_en;
	ctl_word_t        ctl;
	status_t          stat;

	// register file: write in the access phase, no wait states
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_RESET;
			image_height_q <= DIM_RESET;
			bottom_up_q    <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_IMAGE_WIDTH:  image_width_q  <= pwdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[DIM_W-1:0];
				REG_BOTTOM_UP:    bottom_up_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_IMAGE_WIDTH:  prdata = PDATA_W'(image_width_q);
			REG_IMAGE_HEIGHT: prdata = PDATA_W'(image_height_q);
			REG_BOTTOM_UP:    prdata = PDATA_W'(bottom_up_q);
			default:          prdata = '0;
		endcase
	end

	// take input words only while the program rests in its idle step
	assign in_stall = (ctl.op != OP_IDLE);

	obg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	obg_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.in_valid     (in_valid),
		.in_data      (in_data),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.bottom_up    (bottom_up_q),
		.out_stall    (out_stall),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_data     (out_data)
	);

	// a result appears only out of the DONE step
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl.op == OP_DONE))
		else $error("result raised outside the DONE step");

	// an accepted grow occupies the sequencer on the next cycle
	a_grow_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.action) |=> in_stall)
		else $error("grow word did not start the program");

	// a load leaves the block ready for the next word
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !in_data.action) |=> !in_stall)
		else $error("load word stalled the input");

	// every reported grow ran at least one pass
	a_pass_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.pass_count != '0))
		else $error("result with zero passes");

endmodule

>>> rtl/obg_seq.sv
// obg_seq: step counter and jump logic over the control store.
// Depends on obg_pkg.
module obg_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  obg_pkg::status_t     stat,
	output obg_pkg::ctl_word_t   ctl
);
	import obg_pkg::*;

	step_t pc_q;
	step_t pc_d;

	assign ctl = ctl_rom(pc_q);

	always_comb begin
		pc_d = pc_q;
		unique case (ctl.op)
			OP_IDLE:  if (stat.start) pc_d = ctl.tgt_a;
			OP_PASS:  pc_d = ctl.tgt_a;
			OP_START: pc_d = (stat.at_limit || stat.span_empty) ? ctl.tgt_b : ctl.tgt_a;
			OP_CHECK: begin
				if (stat.hit)
					pc_d = ctl.tgt_a;
				else if (stat.at_end)
					pc_d = ctl.tgt_b;
			end
			OP_TEST:  pc_d = stat.changed ? ctl.tgt_a : ctl.tgt_b;
			OP_DONE:  if (stat.out_free) pc_d = ctl.tgt_a;
			default:  pc_d = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= STEP_IDLE;
		else
			pc_q <= pc_d;
	end

endmodule

>>> rtl/obg_dp.sv
// obg_dp: box edge registers, scan index, opaque mask memory and result register.
// Depends on obg_pkg; driven by the control word from obg_seq.
module obg_dp #(
	parameter int MAX_WIDTH  = obg_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = obg_pkg::MAX_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  obg_pkg::ctl_word_t          ctl,
	input  logic                        in_valid,
	input  obg_pkg::in_word_t           in_data,
	input  logic [obg_pkg::DIM_W-1:0]   image_width,
	input  logic [obg_pkg::DIM_W-1:0]   image_height,
	input  logic                        bottom_up,
	input  logic                        out_stall,
	output obg_pkg::status_t            stat,
	output logic                        out_valid,
	output obg_pkg::out_word_t          out_data
);
	import obg_pkg::*;

	localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int CW      = $clog2(MAX_DIM + 1);
	localparam int CAW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RAW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AW      = CAW + RAW;
	localparam int DEPTH   = 1 << AW;

	logic          mask_q [DEPTH];
	logic          rd_q;
	logic [CW-1:0] l_q, r_q, t_q, b_q, idx_q;
	logic [PASS_W-1:0] pass_q;
	logic          changed_q;
	logic          out_valid_q;
	out_word_t     out_q;

	logic [CW-1:0] ew, eh;
	logic [CW-1:0] line, span_lo, span_hi, idx_n, rd_col, rd_row, stored;
	logic          col_walk, at_limit;
	logic          start, we, out_free;
	logic [AW-1:0] addr;

	function automatic logic [CW-1:0] clamp_edge(input logic [15:0] v,
			input logic [CW-1:0] lim);
		logic [CW-1:0] res;
		if (v[15])
			res = '0;
		else if (32'({1'b0, v[14:0]}) >= 32'(lim))
			res = lim - CW'(1);
		else
			res = CW'({1'b0, v[14:0]});
		return res;
	endfunction

	// effective image size: zero acts as one, clip at the mask size
	always_comb begin
		if (image_width == '0)
			ew = CW'(1);
		else if (32'(image_width) > 32'(MAX_WIDTH))
			ew = CW'(MAX_WIDTH);
		else
			ew = CW'(image_width);
		if (image_height == '0)
			eh = CW'(1);
		else if (32'(image_height) > 32'(MAX_HEIGHT))
			eh = CW'(MAX_HEIGHT);
		else
			eh = CW'(image_height);
	end

	always_comb begin
		col_walk = 1'b1;
		at_limit = 1'b0;
		line     = l_q - CW'(1);
		span_lo  = t_q;
		span_hi  = b_q;
		unique case (ctl.dir)
			DIR_LEFT: begin
				at_limit = (l_q == '0);
				line     = l_q - CW'(1);
			end
			DIR_RIGHT: begin
				at_limit = (r_q == ew - CW'(1));
				line     = r_q + CW'(1);
			end
			DIR_TOP: begin
				col_walk = 1'b0;
				at_limit = (t_q == '0);
				line     = t_q - CW'(1);
				span_lo  = l_q;
				span_hi  = r_q;
			end
			DIR_BOTTOM: begin
				col_walk = 1'b0;
				at_limit = (b_q == eh - CW'(1));
				line     = b_q + CW'(1);
				span_lo  = l_q;
				span_hi  = r_q;
			end
			default: at_limit = 1'b1;
		endcase
	end

	// read ahead: START fetches the first span entry, CHECK fetches the next
	assign idx_n  = (ctl.op == OP_START) ? span_lo : idx_q + CW'(1);
	assign rd_col = col_walk ? line : idx_n;
	assign rd_row = col_walk ? idx_n : line;
	assign stored = bottom_up ? (eh - CW'(1) - rd_row) : rd_row;

	assign start = (ctl.op == OP_IDLE) && in_valid && in_data.action;
	assign we    = (ctl.op == OP_IDLE) && in_valid && !in_data.action
		&& (32'(in_data.pixel_col) < 32'(MAX_WIDTH))
		&& (32'(in_data.pixel_row) < 32'(MAX_HEIGHT));
	assign addr  = we ? {RAW'(32'(in_data.pixel_row)), CAW'(32'(in_data.pixel_col))}
		: {stored[RAW-1:0], rd_col[CAW-1:0]};

	always_ff @(posedge clk) begin
		if (we)
			mask_q[addr] <= (in_data.alpha != '0);
		rd_q <= mask_q[addr];
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_IDLE: begin
				if (start) begin
					l_q    <= clamp_edge(in_data.seed_left, ew);
					r_q    <= clamp_edge(in_data.seed_right, ew);
					t_q    <= clamp_edge(in_data.seed_top, eh);
					b_q    <= clamp_edge(in_data.seed_bottom, eh);
					pass_q <= '0;
				end
			end
			OP_PASS: begin
				if (pass_q != PASS_LIMIT)
					pass_q <= pass_q + PASS_W'(1);
				changed_q <= 1'b0;
			end
			OP_START: idx_q <= span_lo;
			OP_CHECK: begin
				if (rd_q) begin
					changed_q <= 1'b1;
					case (ctl.dir)
						DIR_LEFT:   l_q <= line;
						DIR_RIGHT:  r_q <= line;
						DIR_TOP:    t_q <= line;
						DIR_BOTTOM: b_q <= line;
						default:    l_q <= l_q;
					endcase
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == OP_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_DONE && out_free)
			out_q <= '{box_left: 8'(l_q), box_right: 8'(r_q), box_top: 8'(t_q),
				box_bottom: 8'(b_q), pass_count: pass_q};
	end

	assign stat = '{start: start, at_limit: at_limit,
		span_empty: (span_lo > span_hi), hit: rd_q,
		at_end: (idx_q == span_hi), changed: changed_q, out_free: out_free};

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for opaque_bbox_grow, with box prediction and result checking.
// Depends on obg_pkg and the opaque_bbox_grow RTL; needs nothing else.

module tb;
	import obg_pkg::*;

	localparam int MASK_SIDE   = MAX_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int SETTLE      = 50;
	localparam int PRINT_CAP   = 40;

	// action codes of an input word
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_GROW = 1'b1;

	// Mirror of the opaque mask and the registers, plus the queue of boxes
	// that accepted grow words still owe. Grows are predicted the moment
	// their word is taken, so the mask seen is exactly the one the block sees.
	class bbox_ledger;
		bit          opaque [MASK_SIDE*MASK_SIDE];
		int unsigned img_cols = 256;
		int unsigned img_rows = 256;
		bit          flip = 1'b0;
		out_word_t   boxes_due[$];
		int          faults = 0;

		task flag(string msg);
			if (faults < PRINT_CAP)
				$display("[%0t] mismatch: %s", $time, msg);
			faults++;
		endtask

		function void note_reg(logic [1:0] idx, int unsigned value);
			case (idx)
				REG_IMAGE_WIDTH:  img_cols = value & 32'h1FF;
				REG_IMAGE_HEIGHT: img_rows = value & 32'h1FF;
				REG_BOTTOM_UP:    flip = value[0];
				default: ;
			endcase
		endfunction

		// 0 acts as 1, anything past the mask acts as the mask size
		function int span_of(int unsigned v, int maxv);
			if (v == 0)
				return 1;
			if (v > maxv)
				return maxv;
			return v;
		endfunction

		function int pin(int v, int lim);
			if (v < 0)
				return 0;
			if (v >= lim)
				return lim - 1;
			return v;
		endfunction

		function bit lit(int col, int row, int ht);
			int stored;
			stored = flip ? ht - 1 - row : row;
			return opaque[stored*MASK_SIDE + col];
		endfunction

		function bit col_hit(int col, int r0, int r1, int ht);
			for (int r = r0; r <= r1; r++)
				if (lit(col, r, ht))
					return 1'b1;
			return 1'b0;
		endfunction

		function bit row_hit(int row, int c0, int c1, int ht);
			for (int c = c0; c <= c1; c++)
				if (lit(c, row, ht))
					return 1'b1;
			return 1'b0;
		endfunction

		function out_word_t grow_box(in_word_t w);
			out_word_t   res;
			int          wd, ht, l, r, t, b, pl, pr, pt, pb;
			int unsigned passes;
			wd = span_of(img_cols, MASK_SIDE);
			ht = span_of(img_rows, MASK_SIDE);
			l = pin($signed(w.seed_left), wd);
			r = pin($signed(w.seed_right), wd);
			t = pin($signed(w.seed_top), ht);
			b = pin($signed(w.seed_bottom), ht);
			passes = 0;
			do begin
				if (passes < PASS_LIMIT)
					passes++;
				pl = l;
				pr = r;
				pt = t;
				pb = b;
				while (l > 0 && col_hit(l - 1, t, b, ht))
					l--;
				while (r < wd - 1 && col_hit(r + 1, t, b, ht))
					r++;
				while (t > 0 && row_hit(t - 1, l, r, ht))
					t--;
				while (b < ht - 1 && row_hit(b + 1, l, r, ht))
					b++;
			end while (l != pl || r != pr || t != pt || b != pb);
			res.box_left   = l[7:0];
			res.box_right  = r[7:0];
			res.box_top    = t[7:0];
			res.box_bottom = b[7:0];
			res.pass_count = passes[PASS_W-1:0];
			return res;
		endfunction

		function void take_word(in_word_t w);
			if (w.action == ACT_LOAD)
				opaque[{w.pixel_row, w.pixel_col}] = (w.alpha != 8'd0);
			else
				boxes_due.push_back(grow_box(w));
		endfunction

		task match_box(out_word_t got);
			out_word_t want;
			if (boxes_due.size() == 0) begin
				flag("box word with no grow outstanding");
				return;
			end
			want = boxes_due.pop_front();
			if (got.box_left !== want.box_left)
				flag($sformatf("box_left %0d, want %0d", got.box_left, want.box_left));
			if (got.box_right !== want.box_right)
				flag($sformatf("box_right %0d, want %0d", got.box_right, want.box_right));
			if (got.box_top !== want.box_top)
				flag($sformatf("box_top %0d, want %0d", got.box_top, want.box_top));
			if (got.box_bottom !== want.box_bottom)
				flag($sformatf("box_bottom %0d, want %0d", got.box_bottom, want.box_bottom));
			if (got.pass_count !== want.pass_count)
				flag($sformatf("pass_count %0d, want %0d", got.pass_count, want.pass_count));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	in_word_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_word_t          out_data;

	bbox_ledger ledger = new;

	// Stimulus side record of which mask bits hold a load since reset. A grow
	// is only sent once every pixel of the image in use has been loaded, so
	// the block never reads a bit it was not given.
	bit loaded [MASK_SIDE*MASK_SIDE];

	// 1 = no gaps on the input and no stalls on the output for this phase
	bit calm;
	int cycle_count;

	opaque_bbox_grow dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run as failed once the cycle limit is reached.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb failed");
		$finish;
	end

	// Receiver back-pressure. Mostly short stalls, now and then a long one,
	// none at all in calm phases. Changes only on the falling edge.
	initial begin
		int hold;
		int pick;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (calm) begin
				out_stall = 1'b0;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					out_stall = 1'b0;
				end else if (pick < 93) begin
					out_stall = 1'b1;
					hold = $urandom_range(0, 3);
				end else begin
					out_stall = 1'b1;
					hold = $urandom_range(8, 40);
				end
			end
		end
	end

	// Both channels are sampled on the rising edge, before the block's own
	// updates land. Take inputs first so a grow accepted on the same edge as
	// an older result queues behind it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				ledger.take_word(in_data);
			if (out_valid && !out_stall)
				ledger.match_box(out_data);
		end
	end

	function automatic int pick_gap();
		int pick;
		if (calm)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Every field random, so the ignored half of each word toggles too.
	function automatic in_word_t noise_word();
		in_word_t w;
		w.action      = 1'($urandom);
		w.pixel_col   = 8'($urandom);
		w.pixel_row   = 8'($urandom);
		w.alpha       = 8'($urandom);
		w.seed_left   = 16'($urandom);
		w.seed_right  = 16'($urandom);
		w.seed_top    = 16'($urandom);
		w.seed_bottom = 16'($urandom);
		return w;
	endfunction

	function automatic logic [7:0] pick_alpha(int density);
		if ($urandom_range(0, 99) < density)
			return 8'($urandom_range(1, 255));
		return 8'd0;
	endfunction

	// Present one word on the falling edge, hold it until taken. With no gap
	// valid simply stays high into the next word.
	task automatic send(input in_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_data  = w;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic load_px(input int col, input int row, input logic [7:0] a);
		in_word_t w;
		w = noise_word();
		w.action    = ACT_LOAD;
		w.pixel_col = col[7:0];
		w.pixel_row = row[7:0];
		w.alpha     = a;
		loaded[row*MASK_SIDE + col] = 1'b1;
		send(w);
	endtask

	task automatic grow(input int l, input int r, input int t, input int b);
		in_word_t w;
		w = noise_word();
		w.action      = ACT_GROW;
		w.seed_left   = 16'(l);
		w.seed_right  = 16'(r);
		w.seed_top    = 16'(t);
		w.seed_bottom = 16'(b);
		send(w);
	endtask

	// Load every pixel of the image in use that has not been loaded yet.
	task automatic fill_image(input int density);
		int wd, ht;
		wd = ledger.span_of(ledger.img_cols, MASK_SIDE);
		ht = ledger.span_of(ledger.img_rows, MASK_SIDE);
		for (int row = 0; row < ht; row++)
			for (int col = 0; col < wd; col++)
				if (!loaded[row*MASK_SIDE + col])
					load_px(col, row, pick_alpha(density));
	endtask

	// Drop valid and wait until every owed box is back, then a little more
	// so a trailing load has been written before the registers move.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (ledger.boxes_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// APB write (setup, access) followed by a read back of the same register.
	task automatic set_reg(input logic [1:0] idx, input int unsigned value);
		logic [PDATA_W-1:0] keep;
		keep = (idx == REG_BOTTOM_UP) ? (value & 32'h1) : (value & 32'h1FF);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		ledger.note_reg(idx, value);
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== keep)
			ledger.flag($sformatf("register %0d reads %0h, want %0h", idx, prdata, keep));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic configure(input int unsigned cols, input int unsigned rows, input bit bu);
		drain();
		set_reg(REG_IMAGE_WIDTH, cols);
		set_reg(REG_IMAGE_HEIGHT, rows);
		set_reg(REG_BOTTOM_UP, 32'(bu));
	endtask

	// Mixed traffic: loads mostly inside the image, grows mostly seeded
	// inside it, with some raw 16-bit seeds and crossed boxes.
	task automatic mixed_traffic(input int count, input int density, input int grow_pct);
		int wd, ht, l, r, t, b, x;
		wd = ledger.span_of(ledger.img_cols, MASK_SIDE);
		ht = ledger.span_of(ledger.img_rows, MASK_SIDE);
		repeat (count) begin
			if ($urandom_range(0, 99) < grow_pct) begin
				if ($urandom_range(0, 99) < 80) begin
					l = $urandom_range(0, wd - 1);
					r = $urandom_range(0, wd - 1);
					t = $urandom_range(0, ht - 1);
					b = $urandom_range(0, ht - 1);
					if ($urandom_range(0, 99) < 70) begin
						if (l > r) begin x = l; l = r; r = x; end
						if (t > b) begin x = t; t = b; b = x; end
					end
					grow(l, r, t, b);
				end else begin
					grow($signed(16'($urandom)), $signed(16'($urandom)),
					     $signed(16'($urandom)), $signed(16'($urandom)));
				end
			end else if ($urandom_range(0, 99) < 85) begin
				load_px($urandom_range(0, wd - 1), $urandom_range(0, ht - 1),
				        pick_alpha(density));
			end else begin
				load_px($urandom_range(0, 255), $urandom_range(0, 255), pick_alpha(density));
			end
		end
	endtask

	initial begin
		int unsigned cols, rows;
		logic [15:0] shape;
		logic [7:0]  shades [4];

		// drive every input to a known value before the first edge
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		in_valid = 1'b0;
		in_data  = '0;
		calm     = 1'b0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: 4x4 image with a fixed opaque shape, opaque alphas at the
		// byte's extremes and its middle, two loads outside the image but inside
		// the mask, then seeds at the 16-bit extremes, crossed spans and single points.
		configure(4, 4, 1'b0);
		shape  = 16'b0110_0011_1001_0100;
		shades = '{8'h01, 8'hFF, 8'h80, 8'h7F};
		for (int i = 0; i < 16; i++)
			load_px(i % 4, i / 4, shape[i] ? shades[i % 4] : 8'h00);
		load_px(255, 255, 8'hFF);
		load_px(255, 0, 8'h00);
		grow(-32768, -32768, -32768, -32768);
		grow(32767, 32767, 32767, 32767);
		grow(3, 0, 1, 1);
		grow(1, 2, 3, 0);
		grow(-1, 4, -1, 4);
		grow(1, 1, 1, 1);
		grow(2, 2, 2, 2);

		// Widest image, one row, flipped rows.
		configure(256, 1, 1'b1);
		fill_image(70);
		mixed_traffic(30, 70, 40);

		// Tallest image, one column.
		configure(1, 256, 1'b0);
		fill_image(70);
		mixed_traffic(30, 70, 40);

		// Out of range register values: zero acts as one, past the mask
		// acts as the mask size. Both images are already fully loaded.
		configure(0, 511, 1'b1);
		fill_image(60);
		mixed_traffic(30, 60, 40);
		configure(511, 0, 1'b0);
		fill_image(60);
		mixed_traffic(30, 60, 40);

		// Random small images; one phase runs with no idling at all.
		for (int ph = 0; ph < 7; ph++) begin
			cols = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
			rows = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
			configure(cols, rows, 1'($urandom_range(0, 1)));
			calm = (ph == 2);
			fill_image($urandom_range(25, 85));
			mixed_traffic(80, $urandom_range(25, 85), 25);
			calm = 1'b0;
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (ledger.faults == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
